/* sv/assert_macros.svh */
// Assertion macros shared by the blur core.
// Needs clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/bbc_pkg.sv */
// Shared types and constants for the box blur core.
// No dependencies.
`default_nettype none
package bbc_pkg;
    localparam int MAX_RADIUS  = 3;
    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 16;
    localparam int STORE_ROWS  = 3 * MAX_RADIUS + 1;
    localparam int COL_W       = 10;
    localparam int SLOT_W      = 4;
    localparam int ADDR_W      = SLOT_W + COL_W;
    localparam int ROW_W       = 16;
    localparam int SUM_W       = 22;
    localparam int DIVN_W      = 6;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SH    = 28;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  radius;
        logic [10:0] width;   // effective, 1..1024
        logic [15:0] height;  // effective, 1..65535
    } cfg_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [PIXEL_BITS-1:0] wdata;
        logic                  emit;
        logic [ROW_W-1:0]      oy;
        logic [COL_W-1:0]      ox;
        logic [SLOT_W-1:0]     oslot;
        logic                  last;
    } job_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } q_status_t;

    // window size (2R+1)^2
    function automatic logic [DIVN_W-1:0] win_count(input logic [1:0] r);
        logic [DIVN_W-1:0] n;
        case (r)
            2'd0:    n = 6'd1;
            2'd1:    n = 6'd9;
            2'd2:    n = 6'd25;
            default: n = 6'd49;
        endcase
        return n;
    endfunction

    // ceil(2^28 / (2R+1)^2); exact quotient for any 22-bit dividend
    function automatic logic [RECIP_W-1:0] win_recip(input logic [1:0] r);
        logic [RECIP_W-1:0] m;
        case (r)
            2'd0:    m = 29'd268435456;
            2'd1:    m = 29'd29826162;
            2'd2:    m = 29'd10737419;
            default: m = 29'd5478275;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

/* sv/bbc_queue.sv */
// Two-entry job queue between the blur front and back.
// Depends on bbc_pkg.
`default_nettype none
module bbc_queue import bbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire job_t      push_job,
    input  wire logic      pop,
    output job_t           head_job,
    output q_status_t      status
);
    job_t       slot_reg [QUEUE_DEPTH];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_job;
    end

    assign head_job     = slot_reg[rptr_reg];
    assign status.full  = (count_reg == 2'(QUEUE_DEPTH));
    assign status.empty = (count_reg == 2'd0);
    assign status.count = count_reg;
endmodule
`default_nettype wire

/* sv/bbc_front.sv */
// Front of the blur core: config registers, raster tracking, job building.
// Depends on bbc_pkg.
`default_nettype none
module bbc_front import bbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        pix_valid,
    output logic             pix_stall,
    input  wire logic [15:0] pixel_value,
    input  wire logic        drain,
    input  wire q_status_t   q_status,
    output logic             push,
    output job_t             push_job,
    output cfg_t             cfg
);
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    logic [1:0]        radius_reg;
    logic [10:0]       width_reg;
    logic [15:0]       height_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W:0]    in_row_reg;
    logic [SLOT_W-1:0] in_slot_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [11:0]       cnt_reg;

    logic        cfg_wr;
    logic        take;
    logic        active;
    logic        real_item;
    logic        emit;
    logic        last;
    logic [11:0] lag;
    logic [11:0] rw;
    logic        in_wrap;
    logic        out_wrap;

    always_comb
    begin
        cfg.radius = radius_reg;
        if (width_reg == 11'd0)
            cfg.width = 11'd1;
        else if (width_reg > 11'(MAX_WIDTH))
            cfg.width = 11'(MAX_WIDTH);
        else
            cfg.width = width_reg;
        cfg.height = (height_reg == 16'd0) ? 16'd1 : height_reg;
    end

    always_comb
    begin
        case (radius_reg)
            2'd0:    rw = 12'd0;
            2'd1:    rw = 12'(cfg.width);
            2'd2:    rw = {cfg.width, 1'b0};
            default: rw = {cfg.width, 1'b0} + 12'(cfg.width);
        endcase
        lag = rw + 12'(radius_reg);
    end

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign pix_stall = q_status.full;
    assign take      = pix_valid && !pix_stall;
    assign active    = (in_row_reg < {1'b0, cfg.height});
    assign real_item = take && !(active && drain);
    assign emit      = real_item && (cnt_reg == lag);
    assign last      = emit && (out_row_reg == cfg.height - 16'd1)
                       && ({1'b0, out_col_reg} == cfg.width - 11'd1);
    assign in_wrap   = ({1'b0, in_col_reg} + 11'd1) >= cfg.width;
    assign out_wrap  = ({1'b0, out_col_reg} + 11'd1) >= cfg.width;

    always_comb
    begin
        push_job.we    = real_item && active;
        push_job.waddr = {in_slot_reg, in_col_reg};
        push_job.wdata = pixel_value;
        push_job.emit  = emit;
        push_job.oy    = out_row_reg;
        push_job.ox    = out_col_reg;
        push_job.oslot = out_slot_reg;
        push_job.last  = last;
        push           = push_job.we || emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= 2'd1;
            width_reg    <= 11'd1024;
            height_reg   <= 16'd1024;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            cnt_reg      <= '0;
        end
        else if (cfg_wr || last)
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_data[1:0];
                    REG_WIDTH:  width_reg  <= cfg_data[10:0];
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            cnt_reg      <= '0;
        end
        else if (real_item)
        begin
            if (cnt_reg < lag)
                cnt_reg <= cnt_reg + 12'd1;
            if (in_wrap)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= in_row_reg + 17'd1;
                in_slot_reg <= (in_slot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0
                               : in_slot_reg + SLOT_W'(1);
            end
            else
                in_col_reg <= in_col_reg + COL_W'(1);
            // advance the output raster
            if (emit)
            begin
                if (out_wrap)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 16'd1;
                    out_slot_reg <= (out_slot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0
                                    : out_slot_reg + SLOT_W'(1);
                end
                else
                    out_col_reg <= out_col_reg + COL_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

/* sv/bbc_back.sv */
// Back of the blur core: line store, window walk, rounding divider, output.
// Depends on bbc_pkg.
`default_nettype none
module bbc_back import bbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire q_status_t   q_status,
    input  wire job_t        head_job,
    output logic             pop,
    output logic             blur_valid,
    input  wire logic        blur_stall,
    output logic [15:0]      blurred_value,
    output logic             frame_end
);
    typedef enum logic [2:0] {IDLE, READ, FIN, PREP, DIV, HOLD} state_t;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [PIXEL_BITS-1:0] mem [STORE_ROWS * MAX_WIDTH];

    state_t                state_reg;
    logic [COL_W-1:0]      ox_reg;
    logic                  last_reg;
    logic signed [ROW_W+1:0] ry_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic signed [COL_W+1:0] cx_reg;
    logic [2:0]            dxi_reg;
    logic [2:0]            dyi_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic                  rd_vld_reg;
    logic [PIXEL_BITS-1:0] rdata_reg;
    logic [SUM_W-1:0]      x_reg;

    logic [2:0]              span;
    logic [DIVN_W-1:0]       n;
    logic signed [ROW_W+1:0] hmax;
    logic signed [ROW_W+1:0] ry0;
    logic signed [ROW_W+1:0] ry1;
    logic [COL_W-1:0]        col;
    logic [ADDR_W-1:0]       raddr;
    logic [PROD_W-1:0]       prod;
    logic [SLOT_W-1:0]       slot0;
    logic [SLOT_W-1:0]       slot1;

    assign span = {cfg.radius, 1'b0};
    assign n    = win_count(cfg.radius);
    assign hmax = $signed({2'b00, cfg.height}) - 18'sd1;
    assign pop  = (state_reg == IDLE) && !q_status.empty;
    assign ry0  = $signed({2'b00, head_job.oy}) - $signed(18'(cfg.radius));
    assign ry1  = ry_reg + 18'sd1;
    assign prod = PROD_W'(x_reg) * PROD_W'(win_recip(cfg.radius));

    always_comb
    begin
        if (ry0 < 0)
            slot0 = '0;
        else if (head_job.oslot >= SLOT_W'(cfg.radius))
            slot0 = head_job.oslot - SLOT_W'(cfg.radius);
        else
            slot0 = head_job.oslot + SLOT_W'(STORE_ROWS) - SLOT_W'(cfg.radius);
        // clamped row: stay at the top edge, stop at the bottom edge
        if (ry1 <= 0)
            slot1 = '0;
        else if (ry1 <= hmax)
            slot1 = (slot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_reg + SLOT_W'(1);
        else
            slot1 = slot_reg;
    end

    always_comb
    begin
        if (cx_reg < 0)
            col = '0;
        else if (cx_reg > $signed({1'b0, cfg.width} - 12'd1))
            col = COL_W'(cfg.width - 11'd1);
        else
            col = cx_reg[COL_W-1:0];
        raddr = {slot_reg, col};
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_job.we)
            mem[head_job.waddr] <= head_job.wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == READ);
            case (state_reg)
                IDLE:
                begin
                    if (pop && head_job.emit)
                        state_reg <= READ;
                end
                READ:
                begin
                    if (dxi_reg == span && dyi_reg == span)
                        state_reg <= FIN;
                end
                FIN:  state_reg <= PREP;
                PREP: state_reg <= DIV;
                DIV:  state_reg <= HOLD;
                HOLD:
                begin
                    if (!blur_stall)
                        state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
            acc_reg <= acc_reg + SUM_W'(rdata_reg);
        case (state_reg)
            IDLE:
            begin
                ox_reg   <= head_job.ox;
                last_reg <= head_job.last;
                ry_reg   <= ry0;
                slot_reg <= slot0;
                cx_reg   <= $signed({2'b00, head_job.ox}) - $signed(12'(cfg.radius));
                dxi_reg  <= '0;
                dyi_reg  <= '0;
                acc_reg  <= '0;
            end
            READ:
            begin
                if (dxi_reg == span)
                begin
                    dxi_reg  <= '0;
                    cx_reg   <= $signed({2'b00, ox_reg}) - $signed(12'(cfg.radius));
                    dyi_reg  <= dyi_reg + 3'd1;
                    ry_reg   <= ry1;
                    slot_reg <= slot1;
                end
                else
                begin
                    dxi_reg <= dxi_reg + 3'd1;
                    cx_reg  <= cx_reg + 12'sd1;
                end
            end
            PREP:
            begin
                x_reg <= acc_reg + SUM_W'(n >> 1);
            end
            DIV:
            begin
                // divide by the window size through its reciprocal
                x_reg <= prod[SUM_W+RECIP_SH-1:RECIP_SH];
            end
            default: ;
        endcase
    end

    assign blur_valid    = (state_reg == HOLD);
    assign blurred_value = x_reg[15:0];
    assign frame_end     = last_reg;
endmodule
`default_nettype wire

/* sv/box_blur_clamp_edge_core.sv */
// Top level of the streaming box blur with clamp-to-edge borders.
// Depends on bbc_pkg, bbc_front, bbc_queue, bbc_back, assert_macros.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  pixel   | pix_valid/pix_stall  | pixel_value[15:0], drain
//  blur    | blur_valid/blur_stall| blurred_value[15:0], frame_end
//  config  | cfg_valid/cfg_ready  | cfg_index[1:0], cfg_data[15:0]
//
// A pixel that yields no result only costs the back end a line store write.
// For a result, one line-store read port walks the window (READ), then a
// reciprocal multiply rounds the mean (FIN, PREP, DIV) before HOLD shows it.
// Reset is asynchronous; the line store is not cleared and needs no sweep.
// The front keeps taking pixels until the two-entry queue fills.
`default_nettype none
`include "assert_macros.svh"
module box_blur_clamp_edge_core import bbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        pix_valid,
    output logic             pix_stall,
    input  wire logic [15:0] pixel_value,
    input  wire logic        drain,
    output logic             blur_valid,
    input  wire logic        blur_stall,
    output logic [15:0]      blurred_value,
    output logic             frame_end
);
    q_status_t q_status;
    job_t      push_job;
    job_t      head_job;
    cfg_t      cfg;
    logic      push;
    logic      pop;

    bbc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel_value (pixel_value),
        .drain       (drain),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job),
        .cfg         (cfg)
    );

    bbc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    bbc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_status      (q_status),
        .head_job      (head_job),
        .pop           (pop),
        .blur_valid    (blur_valid),
        .blur_stall    (blur_stall),
        .blurred_value (blurred_value),
        .frame_end     (frame_end)
    );

    `BBC_ASSERT(a_no_overflow, push |-> !q_status.full || pop, "queue overflow")
    `BBC_ASSERT(a_no_underflow, pop |-> !q_status.empty, "queue underflow")
    `BBC_ASSERT(a_count_bound, q_status.count <= 2'(QUEUE_DEPTH), "queue count too large")
    `BBC_ASSERT_ALWAYS(a_quiet_reset, !rst_n |-> !blur_valid, "result during reset")
endmodule
`default_nettype wire
